/* src/tra_pkg.sv */
// ----------------------------------------------------------------------------
// Transpose rank transform package
// Shared types, register indices, state codes and the table request word.
// ----------------------------------------------------------------------------
`default_nettype none

package tra_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DIRECTION = 2'd0;
  localparam cfg_idx_t REG_POLICY    = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_D1,
    ST_D2
  } state_t;

  // Requests to a table in the same cycle: two reads and one write.
  typedef struct packed {
    byte_t addr_a;
    byte_t addr_b;
    logic  fwd_b;
    logic  we;
    byte_t waddr;
    byte_t wdata;
  } tbl_req_t;

endpackage

`default_nettype wire

/* src/tra_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, registered reads returning old data on
// a same-address write.
// ----------------------------------------------------------------------------
`default_nettype none

module tra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* src/tra_table.sv */
// ----------------------------------------------------------------------------
// Permutation table
// A RAM with per-entry valid bits so that an unwritten entry reads as its own
// index, plus forwarding of a write to a read of the same entry in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tra_table #(
  parameter int DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tra_pkg::tbl_req_t req,
  output tra_pkg::byte_t        rd_a,
  output tra_pkg::byte_t        rd_b
);

  import tra_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DEPTH-1:0] valid_r;
  logic [AW-1:0]    idx_a;
  logic [AW-1:0]    idx_b;
  logic [AW-1:0]    widx;
  logic             vld_a;
  logic             vld_b;
  byte_t            ram_a;
  byte_t            ram_b;

  byte_t addr_a_r;
  byte_t addr_b_r;
  byte_t wdata_r;
  logic  vld_a_r;
  logic  vld_b_r;
  logic  hit_a_r;
  logic  hit_b_r;

  assign idx_a = req.addr_a[AW-1:0];
  assign idx_b = req.addr_b[AW-1:0];
  assign widx  = req.waddr[AW-1:0];

  // Addresses past the alphabet are only ever read when the data is unused.
  assign vld_a = (int'(idx_a) < DEPTH) ? valid_r[idx_a] : 1'b0;
  assign vld_b = (int'(idx_b) < DEPTH) ? valid_r[idx_b] : 1'b0;

  tra_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (req.we),
    .waddr   (widx),
    .wdata   (req.wdata),
    .raddr_a (idx_a),
    .raddr_b (idx_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[widx] <= 1'b1;
      end
      vld_a_r <= vld_a;
      vld_b_r <= vld_b;
      hit_a_r <= req.we && (req.waddr == req.addr_a);
      // Port B may instead ask for the contents from before this write.
      hit_b_r <= req.we && req.fwd_b && (req.waddr == req.addr_b);
    end
  end

  always_ff @(posedge clk) begin
    addr_a_r <= req.addr_a;
    addr_b_r <= req.addr_b;
    wdata_r  <= req.wdata;
  end

  assign rd_a = hit_a_r ? wdata_r : (vld_a_r ? ram_a : addr_a_r);
  assign rd_b = hit_b_r ? wdata_r : (vld_b_r ? ram_b : addr_b_r);

endmodule

`default_nettype wire

/* src/tra_out_queue.sv */
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue holding result words until the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module tra_out_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tra_pkg::byte_t push_data,
  output logic                space,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tra_pkg::byte_t      out_byte
);

  import tra_pkg::*;

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  byte_t      q0_r;
  byte_t      q1_r;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_byte  = q0_r;
  assign space     = (cnt_r != 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (cnt_r == 2'd1)) begin
        q0_r <= push_data;
      end else begin
        q0_r <= q1_r;
      end
      if (push && (cnt_r != 2'd1)) begin
        q1_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        q0_r <= push_data;
      end else begin
        q1_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

/* src/transpose_rank_transform.sv */
// ----------------------------------------------------------------------------
// Transpose rank transform
// Self-organising byte rank transform: encode maps symbol to rank, decode
// maps rank to symbol, and the item then moves one rank up (or, under the
// seen-prefix policy, an unseen item jumps to the end of the seen prefix).
//
// Input words arrive on in_valid/in_stall/in_byte and one result word per
// input leaves on out_valid/out_stall/out_byte, in order. The direction and
// policy registers are written through cfg_valid/cfg_ready with cfg_index
// and cfg_data; the user must write them only while the block is idle,
// which the block does not enforce. cfg_ready is always high. An encoded
// word steps through E1, E2, E3 and a decoded word through D1, D2, and the
// next word can be taken in E3 or D2; a word outside the alphabet leaves the
// block idle. A result within the alphabet is queued in the cycle after
// acceptance, one outside it at acceptance. Two results can wait in the
// output queue, so a stalled receiver holds off new input only once both
// are full. After reset both tables read as identity, the seen count and
// both registers are zero, and with no clearing pass input is taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module transpose_rank_transform #(
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tra_pkg::byte_t    in_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tra_pkg::byte_t         out_byte,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire tra_pkg::cfg_idx_t cfg_index,
  input  wire logic              cfg_data
);

  import tra_pkg::*;

  localparam int SEEN_W = $clog2(ALPHABET_SIZE + 1);
  localparam int CMP_W  = BYTE_W + 1;

  state_t            state_r;
  state_t            state_nxt;
  byte_t             x_r, x_nxt;
  byte_t             r_r, r_nxt;
  byte_t             t_r, t_nxt;
  byte_t             rr_r, rr_nxt;
  logic              swap_r, swap_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              dir_r;
  logic              pol_r;

  tbl_req_t s2r_req;
  tbl_req_t r2s_req;
  byte_t    s2r_rd_a, s2r_rd_b;
  byte_t    r2s_rd_a, r2s_rd_b;

  logic  push;
  byte_t push_data;
  logic  space;
  logic  accept;
  logic  in_range;
  logic  seen_full;
  logic  enc_grow, dec_grow;
  byte_t enc_t, dec_t;

  function automatic byte_t target_rank(input byte_t r, input logic grow,
                                        input logic [SEEN_W-1:0] seen);
    byte_t t;
    if (grow) begin
      t = BYTE_W'(seen);
    end else if (r != '0) begin
      t = r - byte_t'(1);
    end else begin
      t = r;
    end
    return t;
  endfunction

  assign in_range  = {1'b0, in_byte} < CMP_W'(ALPHABET_SIZE);
  assign seen_full = (seen_r == SEEN_W'(ALPHABET_SIZE));
  assign enc_grow  = pol_r && ({1'b0, s2r_rd_a} >= CMP_W'(seen_r));
  assign dec_grow  = pol_r && ({1'b0, in_byte} >= CMP_W'(seen_r));
  assign enc_t     = target_rank(s2r_rd_a, enc_grow, seen_r);
  assign dec_t     = target_rank(in_byte, dec_grow, seen_r);

  assign in_stall  = !(((state_r == ST_IDLE) || (state_r == ST_E3) ||
                        (state_r == ST_D2)) && space);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    r_nxt     = r_r;
    t_nxt     = t_r;
    rr_nxt    = rr_r;
    swap_nxt  = swap_r;
    seen_nxt  = seen_r;
    push      = 1'b0;
    push_data = in_byte;
    s2r_req   = '{addr_a: in_byte, addr_b: x_r, fwd_b: 1'b1,
                  we: 1'b0, waddr: x_r, wdata: x_r};
    r2s_req   = '{addr_a: in_byte, addr_b: x_r, fwd_b: 1'b1,
                  we: 1'b0, waddr: x_r, wdata: x_r};

    case (state_r)
      ST_E1: begin
        // Rank of the symbol is out; fetch both rank entries for the swap.
        push           = 1'b1;
        push_data      = s2r_rd_a;
        r_nxt          = s2r_rd_a;
        t_nxt          = enc_t;
        swap_nxt       = (enc_t != s2r_rd_a);
        r2s_req.addr_a = enc_t;
        r2s_req.addr_b = s2r_rd_a;
        if (enc_grow && !seen_full) begin
          seen_nxt = seen_r + SEEN_W'(1);
        end
        state_nxt = ST_E2;
      end
      ST_E2: begin
        // The read of the other symbol's rank must see the old contents.
        rr_nxt         = r2s_rd_b;
        s2r_req.addr_b = r2s_rd_a;
        s2r_req.fwd_b  = 1'b0;
        s2r_req.we     = swap_r;
        s2r_req.waddr  = r2s_rd_a;
        s2r_req.wdata  = r_r;
        r2s_req.we     = swap_r;
        r2s_req.waddr  = r_r;
        r2s_req.wdata  = r2s_rd_a;
        state_nxt      = ST_E3;
      end
      ST_E3: begin
        s2r_req.we    = swap_r;
        s2r_req.waddr = x_r;
        s2r_req.wdata = s2r_rd_b;
        r2s_req.we    = swap_r;
        r2s_req.waddr = t_r;
        r2s_req.wdata = rr_r;
        state_nxt     = ST_IDLE;
      end
      ST_D1: begin
        push          = 1'b1;
        push_data     = r2s_rd_a;
        rr_nxt        = r2s_rd_a;
        r2s_req.we    = swap_r;
        r2s_req.waddr = x_r;
        r2s_req.wdata = r2s_rd_b;
        state_nxt     = ST_D2;
      end
      ST_D2: begin
        r2s_req.we    = swap_r;
        r2s_req.waddr = t_r;
        r2s_req.wdata = rr_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (accept) begin
      x_nxt = in_byte;
      if (!in_range) begin
        push      = 1'b1;
        push_data = in_byte;
        state_nxt = ST_IDLE;
      end else if (!dir_r) begin
        s2r_req.addr_a = in_byte;
        state_nxt      = ST_E1;
      end else begin
        r2s_req.addr_a = in_byte;
        r2s_req.addr_b = dec_t;
        t_nxt          = dec_t;
        swap_nxt       = (dec_t != in_byte);
        if (dec_grow && !seen_full) begin
          seen_nxt = seen_r + SEEN_W'(1);
        end
        state_nxt = ST_D1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      swap_r  <= 1'b0;
      seen_r  <= '0;
      dir_r   <= 1'b0;
      pol_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      swap_r  <= swap_nxt;
      seen_r  <= seen_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIRECTION: dir_r <= cfg_data;
          REG_POLICY:    pol_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    r_r  <= r_nxt;
    t_r  <= t_nxt;
    rr_r <= rr_nxt;
  end

  tra_table #(
    .DEPTH (ALPHABET_SIZE)
  ) u_s2r (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (s2r_req),
    .rd_a  (s2r_rd_a),
    .rd_b  (s2r_rd_b)
  );

  tra_table #(
    .DEPTH (ALPHABET_SIZE)
  ) u_r2s (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (r2s_req),
    .rd_a  (r2s_rd_a),
    .rd_b  (r2s_rd_b)
  );

  tra_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
  );

endmodule

`default_nettype wire

/* test/transpose_rank_transform_tb.sv */
// ----------------------------------------------------------------------------
// Transpose rank transform testbench
// Drives byte words through the block in encode and decode mode under both
// move policies. The expected byte is worked out by a local copy of the rank
// tables and seen count, and each result word is checked against the oldest
// prediction. Both sides idle at random, and the register settings change
// between phases without clearing the tables.
// ----------------------------------------------------------------------------
module transpose_rank_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tra_pkg::*;

  localparam int ALPHA       = 256;
  localparam int IDLE_PCT    = 13;
  localparam int CYCLE_LIMIT = 200000;

  localparam cfg_idx_t REG_SPARE_A = 2'd2;
  localparam cfg_idx_t REG_SPARE_B = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  byte_t    in_byte;
  logic     out_valid;
  logic     out_stall;
  byte_t    out_byte;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  logic     cfg_data;

  transpose_rank_transform #(
    .ALPHABET_SIZE(ALPHA)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  byte_t       byte_queue[$];
  byte_t       expected_out[$];
  byte_t       sym_rank[256];
  byte_t       rank_sym[256];
  logic [8:0]  seen_cnt;
  logic        decode_mode;
  logic        prefix_policy;
  int          issued       = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int          cycles       = 0;
  bit          steady       = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_tables();
    int i;
    for (i = 0; i < 256; i++) begin
      sym_rank[i] = byte_t'(i);
      rank_sym[i] = byte_t'(i);
    end
    seen_cnt      = '0;
    decode_mode   = 1'b0;
    prefix_policy = 1'b0;
  endfunction

  // Answers one word from the current tables, then moves the item.
  function automatic byte_t transform_byte(byte_t x);
    int unsigned r;
    int unsigned t;
    int unsigned other;
    bit          grow;
    byte_t       res;
    byte_t       tmp;
    if (x >= ALPHA) return x;
    if (!decode_mode) begin
      r   = sym_rank[x];
      res = byte_t'(r);
    end else begin
      r   = x;
      res = rank_sym[r];
    end
    grow = 1'b0;
    if (prefix_policy && r >= seen_cnt) begin
      grow = 1'b1;
      t    = seen_cnt;
    end else begin
      t = (r > 0) ? r - 1 : r;
    end
    if (t != r) begin
      if (!decode_mode) begin
        other           = rank_sym[t];
        tmp             = sym_rank[x];
        sym_rank[x]     = sym_rank[other];
        sym_rank[other] = tmp;
      end
      tmp         = rank_sym[r];
      rank_sym[r] = rank_sym[t];
      rank_sym[t] = tmp;
    end
    if (grow && seen_cnt < ALPHA) seen_cnt++;
    return res;
  endfunction

  function automatic byte_t pick_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return byte_t'($urandom_range(0, 15));
    if (pick == 5) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Driver: the head of byte_queue is the word on offer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) void'(byte_queue.pop_front());
      if (in_valid && in_stall) begin
        // A stalled word is held as it is.
      end else if (byte_queue.size() != 0 &&
                   (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_byte  <= byte_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Monitor: tracks register writes, predicts on acceptance, checks results.
  always @(posedge clk) begin : monitor
    byte_t want;
    if (!rst_n) begin
      clear_tables();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIRECTION: decode_mode   = cfg_data;
          REG_POLICY:    prefix_policy = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("out_byte %0d arrived with no word outstanding", out_byte);
        end else begin
          want = expected_out.pop_front();
          if (out_byte !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("out_byte mismatch: expected %0d, got %0d", want, out_byte);
          end
        end
      end
      if (in_valid && !in_stall) expected_out.push_back(transform_byte(in_byte));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(byte_t b);
    byte_queue.push_back(b);
    issued++;
  endtask

  // The table write-back can trail the result word, so drain waits on past it.
  task automatic drain();
    while (results_seen < issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Called at a rising edge; returns at the edge where the write is taken.
  task automatic write_reg(cfg_idx_t idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(logic dir, logic pol);
    drain();
    write_reg(REG_DIRECTION, dir);
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, logic'($urandom_range(0, 1)));
    write_reg(REG_POLICY, pol);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic dir, logic pol, int n);
    configure(dir, pol);
    repeat (n) send(pick_byte());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DIRECTION;
    cfg_data  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Encode from reset values: rank zero stays put, the extremes move up.
    send(8'h00); send(8'hFF); send(8'hFF); send(8'h01);
    send(8'h80); send(8'h7F); send(8'hAA); send(8'h55);

    // Seen-prefix policy: unseen symbols jump to the end of the prefix.
    configure(1'b0, 1'b1);
    send(8'h09); send(8'h09); send(8'hC8); send(8'h00); send(8'hFF);

    // Decoding the rank equal to the seen count only grows the prefix.
    configure(1'b1, 1'b1);
    send(8'h04); send(8'h05); send(8'h00); send(8'hFF); send(8'h01);

    configure(1'b1, 1'b0);
    send(8'h00); send(8'h01); send(8'hFF);

    run_phase(1'b0, 1'b0, 150);
    run_phase(1'b1, 1'b0, 150);
    drain();
    steady = 1;
    run_phase(1'b0, 1'b1, 200);
    drain();
    steady = 0;

    // Drive the seen prefix to the whole alphabet, then work beyond it.
    configure(1'b1, 1'b1);
    repeat (260) send(8'hFF);
    repeat (80) send(pick_byte());

    run_phase(1'b0, 1'b1, 150);
    run_phase(1'b1, 1'b0, 100);
    run_phase(1'b0, 1'b0, 80);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
